[hw/rtl/huffman_code_builder_core_macros.svh]
// Assertion macros for the Huffman code builder checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define HCB_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("hcb check failed");

// next-cycle implication, held off during reset
`define HCB_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hcb check failed");

// next-cycle implication, live through reset
`define HCB_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("hcb check failed");

`endif

[hw/rtl/hcb_pkg.sv]
// Shared sizes, types and controller/datapath interface for the Huffman code builder.
// No dependencies.
package hcb_pkg;

  localparam int MAX_LEAVES = 16;
  localparam int NODE_SLOTS = 2 * MAX_LEAVES;
  localparam int IW         = $clog2(NODE_SLOTS);     // node index
  localparam int DW         = $clog2(MAX_LEAVES);     // subtree depth
  localparam int WEIGHT_W   = 16;
  localparam int WW         = WEIGHT_W + $clog2(MAX_LEAVES);  // summed weight
  localparam int SYM_W      = 4;
  localparam int CODE_W     = 15;
  localparam int LEN_W      = 4;
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 24;

  typedef logic [IW-1:0] idx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_MERGE_A,
    ST_MERGE_B,
    ST_MERGE_K,
    ST_WALK_INIT,
    ST_WALK_REQ,
    ST_WALK_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic merge_a;
    logic merge_b;
    logic merge_k;
    logic walk_init;
    logic walk_req;
    logic walk_chk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic load_end;
    logic multi;
    logic scan_last;
    logic more_merge;
    logic at_root;
    logic last_leaf;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/hcb_datapath.sv]
// Datapath: node store memories, two-smallest scan, merge writes, code walk, output register.
// Depends on hcb_pkg.
module hcb_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  hcb_pkg::cmd_t             cmd,
  output hcb_pkg::sts_t             sts,
  input  logic [hcb_pkg::WEIGHT_W-1:0] weight,
  input  logic                      last,
  input  logic                      m_tready,
  output logic                      m_tvalid,
  output logic [hcb_pkg::M_DATA_W-1:0] m_tdata,
  output logic                      m_tlast
);
  import hcb_pkg::*;

  // pmem: {parent, is_right}; wmem: {weight, depth}
  logic [IW:0]      pmem [NODE_SLOTS];
  logic [WW+DW-1:0] wmem [NODE_SLOTS];
  logic [IW:0]      rd_p;
  logic [WW+DW-1:0] rd_w;

  idx_t leaf_cnt, n, k, scan_ptr, sidx, node, leaf;
  logic sv;
  logic b1_ok, b2_ok;
  logic [WW-1:0] b1_w, b2_w;
  logic [DW-1:0] b1_d, b2_d;
  idx_t b1_i, b2_i;
  logic [CODE_W-1:0] code;
  logic [DW-1:0] len;

  idx_t raddr, pwa, wwa, l_i, r_i;
  logic pwe, wwe, swap, cand, lt1, lt2;
  logic [IW:0] pwd;
  logic [WW+DW-1:0] wwd;
  logic [WW-1:0] sum, cw;
  logic [DW-1:0] cd, new_d;

  function automatic logic key_less(input logic [WW-1:0] wa, input logic [DW-1:0] da,
                                    input logic [WW-1:0] wb, input logic [DW-1:0] db);
    key_less = (wa < wb) || ((wa == wb) && (da < db));
  endfunction

  always_comb begin
    swap  = b1_d > b2_d;
    l_i   = swap ? b2_i : b1_i;
    r_i   = swap ? b1_i : b2_i;
    sum   = b1_w + b2_w;
    new_d = (swap ? b1_d : b2_d) + DW'(1);
    raddr = cmd.walk_req ? node : scan_ptr;

    pwe = cmd.load | cmd.merge_a | cmd.merge_b | cmd.merge_k;
    pwa = k;
    pwd = '0;
    if (cmd.load) begin
      pwa = leaf_cnt + IW'(1);
    end else if (cmd.merge_a) begin
      pwa = l_i;
      pwd = {k, 1'b0};
    end else if (cmd.merge_b) begin
      pwa = r_i;
      pwd = {k, 1'b1};
    end

    wwe = cmd.load | cmd.merge_a;
    wwa = cmd.load ? leaf_cnt + IW'(1) : k;
    wwd = cmd.load ? {WW'(weight), DW'(0)} : {sum, new_d};

    cw   = rd_w[WW+DW-1:DW];
    cd   = rd_w[DW-1:0];
    cand = sv && (rd_p[IW:1] == '0);
    lt1  = !b1_ok || key_less(cw, cd, b1_w, b1_d);
    lt2  = !b2_ok || key_less(cw, cd, b2_w, b2_d);

    sts.load_end   = last || (leaf_cnt == IW'(MAX_LEAVES - 1));
    sts.multi      = leaf_cnt != '0;
    sts.scan_last  = scan_ptr == (k - IW'(1));
    sts.more_merge = ({1'b0, k} + (IW+1)'(1)) < {n, 1'b0};
    sts.at_root    = rd_p[IW:1] == '0;
    sts.last_leaf  = leaf == n;
    sts.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= pwd;
    if (wwe) wmem[wwa] <= wwd;
    rd_p <= pmem[raddr];
    rd_w <= wmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_cnt <= '0;
      sv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (sts.load_end) begin
          leaf_cnt <= '0;
          n        <= leaf_cnt + IW'(1);
          k        <= leaf_cnt + IW'(2);
          leaf     <= IW'(1);
        end else begin
          leaf_cnt <= leaf_cnt + IW'(1);
        end
      end

      sv   <= cmd.scan_step;
      sidx <= scan_ptr;
      if (cmd.scan_init) begin
        scan_ptr <= IW'(1);
        b1_ok    <= 1'b0;
        b2_ok    <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_ptr <= scan_ptr + IW'(1);
      end
      if (cand && !cmd.scan_init) begin
        if (lt1) begin
          b2_ok <= b1_ok; b2_w <= b1_w; b2_d <= b1_d; b2_i <= b1_i;
          b1_ok <= 1'b1;  b1_w <= cw;   b1_d <= cd;   b1_i <= sidx;
        end else if (lt2) begin
          b2_ok <= 1'b1;  b2_w <= cw;   b2_d <= cd;   b2_i <= sidx;
        end
      end

      if (cmd.merge_k) k <= k + IW'(1);

      if (cmd.walk_init) begin
        node <= leaf;
        code <= '0;
        len  <= '0;
      end else if (cmd.walk_chk && !sts.at_root) begin
        code <= code | (CODE_W'(rd_p[0]) << len);
        len  <= len + DW'(1);
        node <= rd_p[IW:1];
      end

      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, LEN_W'(len), code, SYM_W'(leaf - IW'(1))};
        m_tlast  <= sts.last_leaf;
        leaf     <= leaf + IW'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/hcb_controller.sv]
// Sequencer for load, merge scans, merge writes and per-leaf code walks.
// Depends on hcb_pkg.
module hcb_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  hcb_pkg::sts_t sts,
  output hcb_pkg::cmd_t cmd
);
  import hcb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:      if (s_tvalid && sts.load_end)
                      state_next = sts.multi ? ST_SCAN_INIT : ST_WALK_INIT;
      ST_SCAN_INIT: state_next = ST_SCAN;
      ST_SCAN:      if (sts.scan_last) state_next = ST_SCAN_END;
      ST_SCAN_END:  state_next = ST_MERGE_A;
      ST_MERGE_A:   state_next = ST_MERGE_B;
      ST_MERGE_B:   state_next = ST_MERGE_K;
      ST_MERGE_K:   state_next = sts.more_merge ? ST_SCAN_INIT : ST_WALK_INIT;
      ST_WALK_INIT: state_next = ST_WALK_REQ;
      ST_WALK_REQ:  state_next = ST_WALK_CHK;
      ST_WALK_CHK:  state_next = sts.at_root ? ST_EMIT : ST_WALK_REQ;
      ST_EMIT:      if (sts.out_free)
                      state_next = sts.last_leaf ? ST_LOAD : ST_WALK_INIT;
      default:      state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SCAN_INIT: cmd.scan_init = 1'b1;
      ST_SCAN:      cmd.scan_step = 1'b1;
      ST_MERGE_A:   cmd.merge_a   = 1'b1;
      ST_MERGE_B:   cmd.merge_b   = 1'b1;
      ST_MERGE_K:   cmd.merge_k   = 1'b1;
      ST_WALK_INIT: cmd.walk_init = 1'b1;
      ST_WALK_REQ:  cmd.walk_req  = 1'b1;
      ST_WALK_CHK:  cmd.walk_chk  = 1'b1;
      ST_EMIT:      cmd.emit      = sts.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

[hw/rtl/huffman_code_builder_core.sv]
// Huffman code builder, top level: controller plus datapath.
// Depends on hcb_pkg, hcb_controller, hcb_datapath.
//
// Weights stream in one item per cycle while s_tready is high. A set closes on
// the item with tlast, or on the MAX_LEAVES-th weight. The block then stops
// taking items and builds the tree: each of the n-1 merges scans the parentless
// nodes 1..k-1 through a single memory read port, one node per cycle, keeping
// the two smallest (weight, then depth, then lowest index). The SCAN_INIT state
// sets the scan up and SCAN_END drains the read pipeline, then the MERGE_A,
// MERGE_B and MERGE_K states write both child links and the new node. Codes
// then leave in load order, one item per leaf: each leaf walk climbs parent
// links one level per WALK_REQ and WALK_CHK pair, and the EMIT state waits
// while the output register still holds an item that the sink has not taken.
// The left (0) child of a merge is the node of smaller depth; the first bit
// from the root sits in the highest used position of code_bits. A single
// weight yields a code of length 0. The last code may still wait in the output
// register while the first weight of the next set is taken.
module huffman_code_builder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hcb_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] weight
  input  logic                          s_tlast,   // last weight of the set
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hcb_pkg::M_DATA_W-1:0]  m_tdata,   // [3:0] symbol_index, [18:4] code_bits,
                                                   // [22:19] code_length, [23] zero
  output logic                          m_tlast    // last code of the set
);
  import hcb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hcb_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcb_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .weight   (s_tdata[WEIGHT_W-1:0]),
    .last     (s_tlast),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[hw/rtl/hcb_checker.sv]
// Port-level checks for the Huffman code builder, bound to the top level.
// Depends on hcb_pkg and huffman_code_builder_core_macros.svh.
`include "huffman_code_builder_core_macros.svh"

module hcb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [hcb_pkg::S_DATA_W-1:0]  s_tdata,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [hcb_pkg::M_DATA_W-1:0]  m_tdata,
  input logic                          m_tlast
);
  import hcb_pkg::*;

  // closing a set hands over to the build: no item taken next cycle
  `HCB_ASSERT_NXT(a_stop_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
  // stalled result item holds
  `HCB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
                  m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // no code bit set above the code length
  `HCB_ASSERT_IMP(a_code_fits, m_tvalid, (m_tdata[18:4] >> m_tdata[22:19]) == 15'd0)
  // reset empties the output register
  `HCB_ASSERT_RST(a_rst_empty, rst, !m_tvalid)

endmodule

bind huffman_code_builder_core hcb_checker u_hcb_checker (.*);

[bench/tb.sv]
// Self-checking bench for huffman_code_builder_core: streams weight sets in,
// predicts each leaf code with a local Huffman builder and checks every code item.
// Depends on hcb_pkg and the huffman_code_builder_core RTL.
`timescale 1ns / 1ps

module tb;
  import hcb_pkg::*;

  localparam int SLOTS = 2 * MAX_LEAVES;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } code_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  huffman_code_builder_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [31:0] nw [SLOTS];
  int          np [SLOTS];
  int          nl [SLOTS];
  int          nd [SLOTS];
  int          loaded = 0;
  code_item_t  expected_codes[$];
  int          fails = 0;
  int          sink_wait = 0;

  function automatic int least_free(int top, int skip);
    int best;
    best = 0;
    for (int i = 1; i <= top && i < SLOTS; i++) begin
      if (np[i] != 0 || i == skip) continue;
      if (best == 0 || nw[i] < nw[best] || (nw[i] == nw[best] && nd[i] < nd[best]))
        best = i;
    end
    return best;
  endfunction

  // store one weight; on a set end, build the tree and queue every leaf code
  task automatic predict_weight(input logic [15:0] w, input logic lst);
    int n, a, b, t, node, len;
    logic [31:0] code;
    code_item_t c;
    if (loaded == 0)
      for (int i = 0; i < SLOTS; i++) begin
        nw[i] = 0; np[i] = 0; nl[i] = 0; nd[i] = 0;
      end
    loaded++;
    nw[loaded] = 32'(w);
    if (!lst && loaded < MAX_LEAVES) return;
    n = loaded;
    loaded = 0;
    for (int k = n + 1; k < 2 * n && k < SLOTS; k++) begin
      a = least_free(k - 1, 0);
      b = least_free(k - 1, a);
      if (a == 0 || b == 0) break;
      if (nd[a] > nd[b]) begin
        t = a; a = b; b = t;
      end
      np[a] = k; np[b] = k; nl[k] = a;
      nw[k] = nw[a] + nw[b];
      nd[k] = ((nd[a] > nd[b]) ? nd[a] : nd[b]) + 1;
    end
    for (int leaf = 1; leaf <= n; leaf++) begin
      code = 0; len = 0; node = leaf;
      while (node != 0 && np[node] != 0) begin
        if (nl[np[node]] != node) code |= 32'd1 << len;
        len++;
        node = np[node];
      end
      c.sym  = SYM_W'(leaf - 1);
      c.code = CODE_W'(code);
      c.len  = LEN_W'(len);
      c.last = (leaf == n);
      expected_codes = {expected_codes, c};
    end
  endtask

  // one weight item, after a random gap; tvalid stays high until the next gap
  task automatic send_weight(input logic [15:0] w, input logic lst);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_weight(w, lst);
  endtask

  // code item checker; the sink randomly holds tready low between items
  always @(posedge clk) begin
    code_item_t got, exp_c;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[3:0], m_tdata[18:4], m_tdata[22:19], m_tlast};
        if (expected_codes.size() == 0) begin
          $display("%0t unexpected code item %h", $time, got);
          fails++;
        end else begin
          exp_c = expected_codes.pop_front();
          if (got.sym !== exp_c.sym || got.code !== exp_c.code ||
              got.len !== exp_c.len || got.last !== exp_c.last || m_tdata[23] !== 1'b0) begin
            $display("%0t code item: expected sym %0d bits %h len %0d last %b,",
                     $time, exp_c.sym, exp_c.code, exp_c.len, exp_c.last);
            $display("  got sym %0d bits %h len %0d last %b top %b",
                     got.sym, got.code, got.len, got.last, m_tdata[23]);
            fails++;
          end
        end
        sink_wait = $urandom_range(0, 7);
      end
      if (sink_wait > 0) begin
        m_tready <= 1'b0;
        sink_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic drain_codes();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_and_pairs();
    send_weight(16'd7, 1'b1);
    send_weight(16'd0, 1'b1);
    send_weight(16'hFFFF, 1'b0);
    send_weight(16'hFFFF, 1'b1);
    send_weight(16'd0, 1'b0);
    send_weight(16'd5, 1'b1);
  endtask

  task automatic test_extremes();
    // equal weights exercise the depth and index tie breaks
    for (int i = 0; i < 5; i++) send_weight(16'd3, i == 4);
    // skewed weights: deepest codes
    for (int i = 0; i < MAX_LEAVES; i++) send_weight(16'd1 << i, 1'b0);
    // full store ends the set without last
    for (int i = 0; i < MAX_LEAVES; i++) send_weight(16'hFFFF, 1'b0);
    send_weight(16'hAAAA, 1'b0);
    send_weight(16'h5555, 1'b1);
  endtask

  task automatic test_random_sets(input int items);
    int sent, n, mode;
    logic [15:0] w;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(0, 5) == 0) ? MAX_LEAVES : $urandom_range(1, MAX_LEAVES);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        case (mode)
          0: w = 16'($urandom);
          1: w = 16'($urandom_range(0, 3));
          2: w = 16'd1 << $urandom_range(0, 15);
          default: w = 16'($urandom_range(0, 40));
        endcase
        // on a full set, last is sometimes left low
        send_weight(w, (i == n - 1) && (n < MAX_LEAVES || $urandom_range(0, 1)));
      end
      sent += n;
      if ($urandom_range(0, 9) == 0) drain_codes();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_and_pairs();
    drain_codes();
    test_extremes();
    drain_codes();
    test_random_sets(415);
    drain_codes();
    repeat (100) @(posedge clk);
    if (fails == 0 && expected_codes.size() == 0)
      $display("huffman_code_builder_core: match");
    else
      $display("huffman_code_builder_core: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("huffman_code_builder_core: mismatch");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/hcb_pkg.sv
hw/rtl/hcb_datapath.sv
hw/rtl/hcb_controller.sv
hw/rtl/huffman_code_builder_core.sv
hw/rtl/hcb_checker.sv
bench/tb.sv
